@@ rtl/bjic_pkg.sv @@
// Shared constants, types and register codes for the input conditioner.
`timescale 1ns / 1ps

package bjic_pkg;

    localparam int NUM_BUTTONS        = 5;
    localparam int NUM_CHANNELS       = 9;
    localparam int DEBOUNCE_STEP_DOWN = 2;

    localparam int INTEG_W  = 8;
    localparam int AXIS_W   = 12;
    localparam int REPEAT_W = 16;
    localparam int COUNT_W  = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Direction channels follow the buttons
    localparam int CH_RIGHT = NUM_BUTTONS;
    localparam int CH_LEFT  = NUM_BUTTONS + 1;
    localparam int CH_UP    = NUM_BUTTONS + 2;
    localparam int CH_DOWN  = NUM_BUTTONS + 3;

    typedef logic [NUM_BUTTONS-1:0]  buttons_t;
    typedef logic [NUM_CHANNELS-1:0] channels_t;
    typedef logic [AXIS_W-1:0]       axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_LIMIT   = 4'd0,
        REG_DEBOUNCE_STEP_UP = 4'd1,
        REG_JOY_HIGH_PRESS   = 4'd2,
        REG_JOY_HIGH_RELEASE = 4'd3,
        REG_JOY_LOW_PRESS    = 4'd4,
        REG_JOY_LOW_RELEASE  = 4'd5,
        REG_REPEAT_DELAY     = 4'd6,
        REG_REPEAT_PERIOD    = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [INTEG_W-1:0]  debounce_limit;
        logic [INTEG_W-1:0]  debounce_step_up;
        axis_t               joy_high_press;
        axis_t               joy_high_release;
        axis_t               joy_low_press;
        axis_t               joy_low_release;
        logic [REPEAT_W-1:0] repeat_delay;
        logic [REPEAT_W-1:0] repeat_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_limit:   8'd10,
        debounce_step_up: 8'd1,
        joy_high_press:   12'd3595,
        joy_high_release: 12'd3095,
        joy_low_press:    12'd500,
        joy_low_release:  12'd1000,
        repeat_delay:     16'd100,
        repeat_period:    16'd10
    };

endpackage

@@ rtl/bjic_if.sv @@
// Channel interfaces: poll tick in, conditioned result out, register writes.
`timescale 1ns / 1ps

interface bjic_tick_if;
    import bjic_pkg::*;
    logic     valid;
    logic     ready;
    buttons_t raw_buttons;
    axis_t    joy_x;
    axis_t    joy_y;
    modport source (output valid, output raw_buttons, output joy_x, output joy_y, input ready);
    modport sink   (input valid, input raw_buttons, input joy_x, input joy_y, output ready);
endinterface

interface bjic_result_if;
    import bjic_pkg::*;
    logic      valid;
    logic      ready;
    channels_t held_levels;
    channels_t new_presses;
    modport source (output valid, output held_levels, output new_presses, input ready);
    modport sink   (input valid, input held_levels, input new_presses, output ready);
endinterface

interface bjic_cfg_if;
    import bjic_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/button_joystick_input_conditioner.sv @@
// Top level: debounce, joystick hysteresis and autorepeat for one poll tick per item.
`timescale 1ns / 1ps

// Channel   Dir  Item contents                          Accepted when
// tick      in   raw_buttons[4:0], joy_x[11:0], joy_y  tick.valid && tick.ready
// result    out  held_levels[8:0], new_presses[8:0]    result.valid && result.ready
// cfg       in   index[3:0], data[15:0]                cfg.valid && cfg.ready
//
// One tick per clock sustained; a tick passes the input register, then the
// result register. The whole state update is one pass of per-channel compares,
// an 8-bit integrator add and a 17-bit hold counter between those registers.
// Reset loads the default register values and clears integrators, levels and
// hold counters. A stalled result holds the pipe; tick.ready stays high while
// the input stage is empty or moving on. cfg.ready is always high.

module button_joystick_input_conditioner (
    input  logic        clk,
    input  logic        rst_n,
    bjic_tick_if.sink   tick,
    bjic_result_if.source result,
    bjic_cfg_if.sink    cfg
);
    import bjic_pkg::*;

    cfg_t      cfg_q;

    // input stage
    logic      s1_valid_reg;
    buttons_t  s1_raw_reg;
    axis_t     s1_x_reg;
    axis_t     s1_y_reg;
    logic      s1_advance;
    logic      tick_take;

    // result stage
    logic      out_valid_reg;
    channels_t out_levels_reg;
    channels_t out_presses_reg;
    logic      out_free;

    // state and single-pass logic
    channels_t level_reg;
    channels_t level_next;
    buttons_t  btn_level;
    logic      right_n, left_n, up_n, down_n;
    channels_t repeat_hit;
    channels_t presses;

    assign cfg.ready = 1'b1;

    bjic_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // handshake: result register frees when empty or being taken
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;
    assign tick_take  = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick.ready)
            s1_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_raw_reg <= tick.raw_buttons;
            s1_x_reg   <= tick.joy_x;
            s1_y_reg   <= tick.joy_y;
        end
    end

    // buttons first, then the axes on top of the old direction bits
    bjic_debounce u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (s1_advance),
        .cfg       (cfg_q),
        .raw       (s1_raw_reg),
        .level_old (level_reg[NUM_BUTTONS-1:0]),
        .level_new (btn_level)
    );

    bjic_axis u_axis_x (
        .cfg      (cfg_q),
        .sample   (s1_x_reg),
        .high_old (level_reg[CH_RIGHT]),
        .low_old  (level_reg[CH_LEFT]),
        .high_new (right_n),
        .low_new  (left_n)
    );

    bjic_axis u_axis_y (
        .cfg      (cfg_q),
        .sample   (s1_y_reg),
        .high_old (level_reg[CH_UP]),
        .low_old  (level_reg[CH_DOWN]),
        .high_new (up_n),
        .low_new  (down_n)
    );

    always_comb
    begin
        level_next = '0;
        level_next[NUM_BUTTONS-1:0] = btn_level;
        level_next[CH_RIGHT] = right_n;
        level_next[CH_LEFT]  = left_n;
        level_next[CH_UP]    = up_n;
        level_next[CH_DOWN]  = down_n;
    end

    bjic_autorepeat u_repeat (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_advance),
        .cfg        (cfg_q),
        .level      (level_next),
        .repeat_hit (repeat_hit)
    );

    // rising edges plus autorepeat
    assign presses = (~level_reg & level_next) | repeat_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (s1_advance)
            level_reg <= level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_levels_reg  <= level_next;
            out_presses_reg <= presses;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.held_levels = out_levels_reg;
    assign result.new_presses = out_presses_reg;

endmodule

@@ rtl/bjic_cfg_regs.sv @@
// Configuration register file.
`timescale 1ns / 1ps

module bjic_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bjic_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [bjic_pkg::CFG_DATA_W-1:0] wr_data,
    output bjic_pkg::cfg_t                 cfg
);
    import bjic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_DEBOUNCE_LIMIT:   cfg_next.debounce_limit   = wr_data[INTEG_W-1:0];
                REG_DEBOUNCE_STEP_UP: cfg_next.debounce_step_up = wr_data[INTEG_W-1:0];
                REG_JOY_HIGH_PRESS:   cfg_next.joy_high_press   = wr_data[AXIS_W-1:0];
                REG_JOY_HIGH_RELEASE: cfg_next.joy_high_release = wr_data[AXIS_W-1:0];
                REG_JOY_LOW_PRESS:    cfg_next.joy_low_press    = wr_data[AXIS_W-1:0];
                REG_JOY_LOW_RELEASE:  cfg_next.joy_low_release  = wr_data[AXIS_W-1:0];
                REG_REPEAT_DELAY:     cfg_next.repeat_delay     = wr_data[REPEAT_W-1:0];
                REG_REPEAT_PERIOD:    cfg_next.repeat_period    = wr_data[REPEAT_W-1:0];
                default:              cfg_next = cfg_reg; // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/bjic_debounce.sv @@
// Saturating integrators, one per button, giving the debounced button levels.
`timescale 1ns / 1ps

module bjic_debounce (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  bjic_pkg::cfg_t              cfg,
    input  bjic_pkg::buttons_t          raw,
    input  bjic_pkg::buttons_t          level_old,
    output bjic_pkg::buttons_t          level_new
);
    import bjic_pkg::*;

    localparam logic [INTEG_W-1:0] STEP_DOWN = INTEG_W'(DEBOUNCE_STEP_DOWN);

    logic [INTEG_W-1:0] integ_reg  [NUM_BUTTONS];
    logic [INTEG_W-1:0] integ_next [NUM_BUTTONS];

    always_comb
    begin
        logic [INTEG_W:0] sum;
        sum       = '0;
        level_new = level_old;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            sum = {1'b0, integ_reg[i]} + {1'b0, cfg.debounce_step_up};
            if (raw[i])
            begin
                if (sum >= {1'b0, cfg.debounce_limit})
                begin
                    integ_next[i] = cfg.debounce_limit;
                    level_new[i]  = 1'b1;
                end
                else
                begin
                    integ_next[i] = sum[INTEG_W-1:0];
                end
            end
            else if (integ_reg[i] <= STEP_DOWN)
            begin
                integ_next[i] = '0;
                level_new[i]  = 1'b0;
            end
            else
            begin
                integ_next[i] = integ_reg[i] - STEP_DOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
                integ_reg[i] <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
                integ_reg[i] <= integ_next[i];
        end
    end

endmodule

@@ rtl/bjic_axis.sv @@
// Press/release hysteresis for one joystick axis; release wins on overlap.
`timescale 1ns / 1ps

module bjic_axis (
    input  bjic_pkg::cfg_t  cfg,
    input  bjic_pkg::axis_t sample,
    input  logic            high_old,
    input  logic            low_old,
    output logic            high_new,
    output logic            low_new
);
    import bjic_pkg::*;

    always_comb
    begin
        high_new = high_old;
        if (sample > cfg.joy_high_press)
            high_new = 1'b1;
        if (sample < cfg.joy_high_release)
            high_new = 1'b0;

        low_new = low_old;
        if (sample < cfg.joy_low_press)
            low_new = 1'b1;
        if (sample > cfg.joy_low_release)
            low_new = 1'b0;
    end

endmodule

@@ rtl/bjic_autorepeat.sv @@
// Hold counters, one per channel, producing autorepeat presses.
`timescale 1ns / 1ps

module bjic_autorepeat (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  bjic_pkg::cfg_t      cfg,
    input  bjic_pkg::channels_t level,
    output bjic_pkg::channels_t repeat_hit
);
    import bjic_pkg::*;

    logic [COUNT_W-1:0] count_reg  [NUM_CHANNELS];
    logic [COUNT_W-1:0] count_next [NUM_CHANNELS];
    logic [COUNT_W-1:0] delay;
    logic [COUNT_W-1:0] wrap_at;

    assign delay   = COUNT_W'(cfg.repeat_delay);
    assign wrap_at = delay + COUNT_W'(cfg.repeat_period);

    always_comb
    begin
        logic [COUNT_W-1:0] inc;
        inc        = '0;
        repeat_hit = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            inc = count_reg[i] + COUNT_W'(1);
            if (!level[i])
            begin
                count_next[i] = '0;
            end
            else if (inc >= wrap_at)
            begin
                repeat_hit[i] = 1'b1;
                count_next[i] = delay;
            end
            else
            begin
                repeat_hit[i] = (inc == delay);
                count_next[i] = inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                count_reg[i] <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                count_reg[i] <= count_next[i];
        end
    end

endmodule

@@ test/button_joystick_input_conditioner_tb.sv @@
// Self-checking testbench for the button and joystick input conditioner.
`timescale 1ns / 1ps

module button_joystick_input_conditioner_tb;
    import bjic_pkg::*;

    localparam int    MAX_SHOWN = 10;
    localparam axis_t AXIS_MID  = 12'd2048;

    // Expected result of one poll tick
    typedef struct packed {
        channels_t held;
        channels_t presses;
    } outcome_t;

    logic clk;
    logic rst_n;

    bjic_tick_if   tick_ch ();
    bjic_result_if res_ch ();
    bjic_cfg_if    cfg_ch ();

    button_joystick_input_conditioner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Shadow of the block: registers, integrators, levels and hold counters
    cfg_t               regs_model;
    int unsigned        integ_model [NUM_BUTTONS];
    channels_t          levels_model;
    logic [COUNT_W-1:0] hold_model [NUM_CHANNELS];

    outcome_t outcome_q [$];

    // Errors and results are counted by the checker process only
    int error_count  = 0;
    int results_seen = 0;
    int ticks_sent;
    int settings_used;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("timeout: %0d results still outstanding", outcome_q.size());
        $display("button_joystick_input_conditioner test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Press compare first, release after it, so release wins on overlap
    function automatic channels_t apply_axis(channels_t lv, axis_t a, int hi, int lo);
        if (a > regs_model.joy_high_press)
            lv[hi] = 1'b1;
        if (a < regs_model.joy_high_release)
            lv[hi] = 1'b0;
        if (a < regs_model.joy_low_press)
            lv[lo] = 1'b1;
        if (a > regs_model.joy_low_release)
            lv[lo] = 1'b0;
        return lv;
    endfunction

    function automatic outcome_t condition_tick(buttons_t raw, axis_t jx, axis_t jy);
        channels_t          prev_lv;
        channels_t          lv;
        channels_t          rep;
        int unsigned        sum;
        logic [COUNT_W-1:0] cnt;
        logic [REPEAT_W:0]  wrap_at;
        outcome_t           o;
        prev_lv = levels_model;
        lv      = levels_model;
        rep     = '0;
        // Saturating integrators: up by step_up, down by the fixed step
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (raw[i])
            begin
                sum = integ_model[i] + regs_model.debounce_step_up;
                if (sum >= regs_model.debounce_limit)
                begin
                    integ_model[i] = regs_model.debounce_limit;
                    lv[i] = 1'b1;
                end
                else
                    integ_model[i] = sum;
            end
            else if (integ_model[i] <= DEBOUNCE_STEP_DOWN)
            begin
                integ_model[i] = 0;
                lv[i] = 1'b0;
            end
            else
                integ_model[i] = integ_model[i] - DEBOUNCE_STEP_DOWN;
        end
        lv = apply_axis(lv, jx, CH_RIGHT, CH_LEFT);
        lv = apply_axis(lv, jy, CH_UP, CH_DOWN);
        levels_model = lv;
        // Autorepeat: delay then period, counter reloads to the delay
        wrap_at = regs_model.repeat_delay + regs_model.repeat_period;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (lv[i])
            begin
                cnt = hold_model[i] + 1'b1;
                if ({1'b0, cnt} >= {1'b0, wrap_at})
                begin
                    rep[i] = 1'b1;
                    cnt = COUNT_W'(regs_model.repeat_delay);
                end
                else if (cnt == COUNT_W'(regs_model.repeat_delay))
                    rep[i] = 1'b1;
                hold_model[i] = cnt;
            end
            else
                hold_model[i] = '0;
        end
        o.held    = lv;
        o.presses = (~prev_lv & lv) | rep;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void log_failure(string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
                log_failure($sformatf("unexpected result held_levels=%03h new_presses=%03h",
                                      res_ch.held_levels, res_ch.new_presses));
            else
            begin
                want = outcome_q.pop_front();
                if (res_ch.held_levels !== want.held)
                    log_failure($sformatf("result %0d held_levels: expected %03h, got %03h",
                                          results_seen, want.held, res_ch.held_levels));
                if (res_ch.new_presses !== want.presses)
                    log_failure($sformatf("result %0d new_presses: expected %03h, got %03h",
                                          results_seen, want.presses, res_ch.new_presses));
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle; held low in reset
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Leaves valid high on return so a following item goes out back to back
    task automatic send_tick(buttons_t raw, axis_t jx, axis_t jy);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.raw_buttons <= raw;
        tick_ch.joy_x       <= jx;
        tick_ch.joy_y       <= jy;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        outcome_q.push_back(condition_tick(raw, jx, jy));
        ticks_sent++;
    endtask

    // Sender holds off until every outstanding result has been taken
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_DEBOUNCE_LIMIT:   regs_model.debounce_limit   = val[INTEG_W-1:0];
            REG_DEBOUNCE_STEP_UP: regs_model.debounce_step_up = val[INTEG_W-1:0];
            REG_JOY_HIGH_PRESS:   regs_model.joy_high_press   = val[AXIS_W-1:0];
            REG_JOY_HIGH_RELEASE: regs_model.joy_high_release = val[AXIS_W-1:0];
            REG_JOY_LOW_PRESS:    regs_model.joy_low_press    = val[AXIS_W-1:0];
            REG_JOY_LOW_RELEASE:  regs_model.joy_low_release  = val[AXIS_W-1:0];
            REG_REPEAT_DELAY:     regs_model.repeat_delay     = val[REPEAT_W-1:0];
            REG_REPEAT_PERIOD:    regs_model.repeat_period    = val[REPEAT_W-1:0];
            default: ; // no such register, write dropped
        endcase
    endtask

    // Writes every register, with junk in the unused upper data bits of the narrower
    // ones, then one write to an index past the register map, which must be dropped
    task automatic apply_config(cfg_t c);
        wait_idle();
        write_reg(REG_DEBOUNCE_LIMIT,   {8'($urandom), c.debounce_limit});
        write_reg(REG_DEBOUNCE_STEP_UP, {8'($urandom), c.debounce_step_up});
        write_reg(REG_JOY_HIGH_PRESS,   {4'($urandom), c.joy_high_press});
        write_reg(REG_JOY_HIGH_RELEASE, {4'($urandom), c.joy_high_release});
        write_reg(REG_JOY_LOW_PRESS,    {4'($urandom), c.joy_low_press});
        write_reg(REG_JOY_LOW_RELEASE,  {4'($urandom), c.joy_low_release});
        write_reg(REG_REPEAT_DELAY,     c.repeat_delay);
        write_reg(REG_REPEAT_PERIOD,    c.repeat_period);
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_REPEAT_PERIOD + 1)),
                  CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    // Small limits and short repeat timing so holds reach autorepeat often
    function automatic cfg_t pick_config();
        cfg_t c;
        c.debounce_limit   = INTEG_W'($urandom_range(12, 1));
        c.debounce_step_up = INTEG_W'($urandom_range(4, 1));
        if ($urandom_range(99) < 20)
        begin
            // thresholds anywhere, overlap likely
            c.joy_high_press   = axis_t'($urandom);
            c.joy_high_release = axis_t'($urandom);
            c.joy_low_press    = axis_t'($urandom);
            c.joy_low_release  = axis_t'($urandom);
        end
        else
        begin
            c.joy_high_press   = axis_t'($urandom_range(4000, 2500));
            c.joy_high_release = axis_t'($urandom_range(c.joy_high_press, 2000));
            c.joy_low_press    = axis_t'($urandom_range(1500, 100));
            c.joy_low_release  = axis_t'($urandom_range(2000, c.joy_low_press));
        end
        c.repeat_delay  = ($urandom_range(9) == 0) ? '1 : REPEAT_W'($urandom_range(12));
        c.repeat_period = ($urandom_range(9) == 0) ? '1 : REPEAT_W'($urandom_range(8));
        return c;
    endfunction

    // Axis samples bunched at the rails and around the high press, low press and high release thresholds
    function automatic axis_t pick_axis();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return regs_model.joy_high_press + axis_t'($urandom_range(2)) - 1'b1;
            3:       return regs_model.joy_low_press + axis_t'($urandom_range(2)) - 1'b1;
            4:       return regs_model.joy_high_release + axis_t'($urandom_range(2)) - 1'b1;
            default: return axis_t'($urandom);
        endcase
    endfunction

    // Held patterns with bounce on the buttons, plus a share of pure noise
    task automatic run_hold_sequences(int count);
        buttons_t held_b;
        axis_t    hx;
        axis_t    hy;
        int       run_left;
        int       roll;
        run_left = 0;
        held_b   = '0;
        hx       = AXIS_MID;
        hy       = AXIS_MID;
        for (int n = 0; n < count; n++)
        begin
            // once per batch the sender stops until the pipe has drained
            if (n == count / 3)
                wait_idle();
            if (run_left == 0)
            begin
                held_b   = buttons_t'($urandom);
                hx       = pick_axis();
                hy       = pick_axis();
                run_left = $urandom_range(30, 1);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 10)
                send_tick(buttons_t'($urandom), axis_t'($urandom), axis_t'($urandom));
            else if (roll < 25)
                send_tick(held_b ^ buttons_t'(1 << $urandom_range(NUM_BUTTONS - 1)),
                          hx ^ axis_t'($urandom_range(1)), hy);
            else
                send_tick(held_b, hx, hy);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: rails on both axes, all buttons, integrators rise then fall
    task automatic test_defaults();
        send_tick('1, '1, '0);
        send_tick('0, '0, '1);
        send_tick('0, AXIS_MID, AXIS_MID);
    endtask

    // Limit of zero sets a pressed button at once; zero step_up included
    task automatic test_zero_limit();
        cfg_t c;
        c = CFG_RESET;
        c.debounce_limit   = '0;
        c.debounce_step_up = '0;
        apply_config(c);
        send_tick('1, AXIS_MID, AXIS_MID);
        send_tick('0, AXIS_MID, AXIS_MID);
    endtask

    // Zero delay and/or zero period on the autorepeat counter
    task automatic test_zero_repeat();
        cfg_t c;
        c = CFG_RESET;
        c.debounce_limit = '0;
        c.repeat_delay   = '0;
        c.repeat_period  = '0;
        apply_config(c);
        repeat (3) send_tick(buttons_t'(1), AXIS_MID, AXIS_MID);
        c.repeat_period = REPEAT_W'(3);
        apply_config(c);
        repeat (4) send_tick(buttons_t'(2), AXIS_MID, AXIS_MID);
        c.repeat_delay  = REPEAT_W'(2);
        c.repeat_period = '0;
        apply_config(c);
        repeat (4) send_tick(buttons_t'(4), AXIS_MID, AXIS_MID);
    endtask

    // Press and release thresholds overlapping: release has the last word
    task automatic test_overlap();
        cfg_t c;
        c = CFG_RESET;
        c.joy_high_press   = 12'd100;
        c.joy_high_release = 12'd4000;
        c.joy_low_press    = 12'd4000;
        c.joy_low_release  = 12'd100;
        apply_config(c);
        send_tick('0, 12'd2000, 12'd2000);
        send_tick('0, '1, '0);
        send_tick('0, 12'd2000, 12'd2000);
    endtask

    // Timing shrunk mid-hold: counter past the new wrap point fires and reloads
    task automatic test_change_in_hold();
        cfg_t c;
        c = CFG_RESET;
        c.debounce_limit = '0;
        c.repeat_delay   = REPEAT_W'(3);
        c.repeat_period  = REPEAT_W'(5);
        apply_config(c);
        repeat (6) send_tick(buttons_t'(8), AXIS_MID, AXIS_MID);
        c.repeat_delay  = REPEAT_W'(1);
        c.repeat_period = REPEAT_W'(1);
        apply_config(c);
        send_tick(buttons_t'(8), AXIS_MID, AXIS_MID);
    endtask

    // Three idling patterns, two register settings each; one setting pushes
    // every register but debounce_step_up to an extreme
    task automatic test_random();
        cfg_t c;
        int   send_pct [3] = '{33, 85, 0};
        int   recv_pct [3] = '{85, 33, 0};
        for (int m = 0; m < 3; m++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                c = pick_config();
                if (m == 1 && k == 1)
                begin
                    c.debounce_limit   = '1;
                    c.debounce_step_up = 8'd128;
                    c.joy_high_press   = '0;
                    c.joy_high_release = '0;
                    c.joy_low_press    = '1;
                    c.joy_low_release  = '1;
                    c.repeat_delay     = '1;
                    c.repeat_period    = '1;
                end
                apply_config(c);
                send_idle_pct = send_pct[m];
                recv_idle_pct = recv_pct[m];
                run_hold_sequences(75);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n               <= 1'b0;
        tick_ch.valid       <= 1'b0;
        tick_ch.raw_buttons <= '0;
        tick_ch.joy_x       <= '0;
        tick_ch.joy_y       <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ticks_sent    = 0;
        settings_used = 0;
        // shadow state after reset
        regs_model   = CFG_RESET;
        levels_model = '0;
        foreach (integ_model[i])
            integ_model[i] = 0;
        foreach (hold_model[i])
            hold_model[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_zero_limit();
        test_zero_repeat();
        test_overlap();
        test_change_in_hold();
        test_random();

        wait_idle();
        // two-stage pipe: give any stray result time to show
        repeat (8) @(posedge clk);

        $display("Ran %0d poll ticks, checked %0d results across %0d register settings",
                 ticks_sent, results_seen, settings_used);
        $display("(debounce, joystick hysteresis, autorepeat; %0d errors)", error_count);
        if (error_count == 0 && outcome_q.size() == 0)
            $display("button_joystick_input_conditioner test passed");
        else
            $display("button_joystick_input_conditioner test failed");
        $finish;
    end

endmodule
